@@ rtl/basp_pkg.sv @@
// basp_pkg: shared types and constants of the advertising report sensor parser
// no dependencies; used by basp_front, basp_queue and the top level
package basp_pkg;

    localparam int ADDR_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int MASK_W     = 6;

    // configuration register indexes (address registers sit at 0 .. count-1)
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_IDX = 3'd6;

    localparam logic [2:0] ADDR_LAST_BYTE = 3'd5;

    localparam logic [7:0] SUB_ADV_REPORT = 8'h02;
    localparam logic [7:0] AD_TYPE_MFR    = 8'hFF;
    localparam logic [7:0] MFR_SIGNATURE  = 8'hC2;
    localparam logic [7:0] MFR_MIN_LEN    = 8'd5;

    // byte positions inside one AD structure
    localparam logic [7:0] POS_LEN  = 8'd0;
    localparam logic [7:0] POS_TYPE = 8'd1;
    localparam logic [7:0] POS_SIG  = 8'd2;
    localparam logic [7:0] POS_TLO  = 8'd3;
    localparam logic [7:0] POS_THI  = 8'd4;
    localparam logic [7:0] POS_HUM  = 8'd5;

    // report record queue between front and back
    localparam int RPT_AW    = 2;
    localparam int RPT_DEPTH = 1 << RPT_AW;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_EVT_TYPE,
        PH_ADDR_TYPE,
        PH_ADDR,
        PH_DATA_LEN,
        PH_DATA,
        PH_RSSI,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [15:0] temp;
        logic [7:0]  hum;
    } t_reading;

    // request from the parser to the reading queue
    typedef struct packed {
        logic        wr;
        t_reading    reading;
        logic        commit;
        logic        abort;
        logic [2:0]  dev;
        logic [7:0]  rssi;
    } t_fe_req;

endpackage

@@ rtl/ble_adv_sensor_report_parser.sv @@
// ble_adv_sensor_report_parser: top level, parser front and reading queue back
// depends on basp_pkg, basp_front, basp_queue
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+------------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_subevent i_data_byte i_first_byte
//           |              |              | i_last_byte
//  output   | o_out_valid  | i_out_stall  | o_device_index o_temperature_tenths
//           |              |              | o_humidity o_rssi o_run_last
//  config   | i_cfg_we     | -            | i_cfg_index i_cfg_data
//
// one event byte per cycle unless stalled; the parser does constant work per byte
// a report's readings leave one per cycle when not stalled, after its rssi byte
// o_in_stall rises only while the reading store (2 x PENDING_DEPTH rounded up to a
// power of two) or the four-entry report queue is full
// synchronous active-low reset clears the parser, the queue pointers and the config
module ble_adv_sensor_report_parser #(
    parameter int PENDING_DEPTH = 8,
    parameter int DEVICE_COUNT  = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_subevent,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_first_byte,
    input  logic                             i_last_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [2:0]                       o_device_index,
    output logic signed [15:0]               o_temperature_tenths,
    output logic [7:0]                       o_humidity,
    output logic signed [7:0]                o_rssi,
    output logic                             o_run_last,
    input  logic                             i_cfg_we,
    input  logic [basp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [basp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    basp_pkg::t_fe_req req;
    logic              full;
    logic              accept;
    logic [15:0]       temp_bits;
    logic [7:0]        rssi_bits;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    basp_front #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .DEVICE_COUNT  (DEVICE_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_subevent   (i_subevent),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_req        (req)
    );

    basp_queue #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .o_full         (full),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_device_index (o_device_index),
        .o_temperature  (temp_bits),
        .o_humidity     (o_humidity),
        .o_rssi         (rssi_bits),
        .o_run_last     (o_run_last)
    );

    assign o_temperature_tenths = $signed(temp_bits);
    assign o_rssi               = $signed(rssi_bits);

endmodule

@@ rtl/basp_front.sv @@
// basp_front: byte-wise parser of HCI LE advertising report events
// holds the configuration registers; depends on basp_pkg
module basp_front #(
    parameter int PENDING_DEPTH = 8,
    parameter int DEVICE_COUNT  = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [7:0]                          i_subevent,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_first_byte,
    input  logic                                i_last_byte,
    input  logic                                i_cfg_we,
    input  logic [basp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [basp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output basp_pkg::t_fe_req                   o_req
);

    localparam int CW = $clog2(PENDING_DEPTH + 1);

    logic [basp_pkg::ADDR_W-1:0] r_dev_addr [DEVICE_COUNT];
    logic [basp_pkg::MASK_W-1:0] r_enable_mask;

    basp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_reports_left, n_reports_left;
    logic [2:0]  r_field_cnt, n_field_cnt;
    logic [basp_pkg::ADDR_W-1:0] r_addr_shift, n_addr_shift;
    logic        r_match_valid, n_match_valid;
    logic [2:0]  r_match_idx, n_match_idx;
    logic [7:0]  r_adv_left, n_adv_left;
    logic [7:0]  r_ad_len, n_ad_len;
    logic [7:0]  r_ad_pos, n_ad_pos;
    logic        r_ad_mfr, n_ad_mfr;
    logic        r_ad_ok, n_ad_ok;
    logic [7:0]  r_temp_lo, n_temp_lo;
    logic [15:0] r_temp_stage, n_temp_stage;
    logic [CW-1:0] r_pending, n_pending;

    logic [basp_pkg::ADDR_W-1:0] addr_next;
    logic        hit;
    logic [2:0]  hit_idx;

    assign addr_next = {r_addr_shift[basp_pkg::ADDR_W-9:0], i_data_byte};

    // lowest enabled matching index wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = DEVICE_COUNT - 1; i >= 0; i--) begin
            if (r_enable_mask[i] && (r_dev_addr[i] == addr_next)) begin
                hit     = 1'b1;
                hit_idx = 3'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask <= '0;
            for (int i = 0; i < DEVICE_COUNT; i++) begin
                r_dev_addr[i] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int i = 0; i < DEVICE_COUNT; i++) begin
                if (i_cfg_index == basp_pkg::CFG_IDX_W'(i)) begin
                    r_dev_addr[i] <= i_cfg_data;
                end
            end
            if (i_cfg_index == basp_pkg::CFG_MASK_IDX) begin
                r_enable_mask <= i_cfg_data[basp_pkg::MASK_W-1:0];
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_first_byte) begin
                if (i_subevent != basp_pkg::SUB_ADV_REPORT) begin
                    n_phase = basp_pkg::PH_IDLE;
                end else if (i_data_byte == 8'd0) begin
                    n_phase = basp_pkg::PH_DONE;
                end else begin
                    n_phase = basp_pkg::PH_EVT_TYPE;
                end
            end else begin
                case (r_phase)
                    basp_pkg::PH_EVT_TYPE:  n_phase = basp_pkg::PH_ADDR_TYPE;
                    basp_pkg::PH_ADDR_TYPE: n_phase = basp_pkg::PH_ADDR;
                    basp_pkg::PH_ADDR: begin
                        if (r_field_cnt == basp_pkg::ADDR_LAST_BYTE) begin
                            n_phase = basp_pkg::PH_DATA_LEN;
                        end
                    end
                    basp_pkg::PH_DATA_LEN: begin
                        n_phase = (i_data_byte == 8'd0) ? basp_pkg::PH_RSSI
                                                        : basp_pkg::PH_DATA;
                    end
                    basp_pkg::PH_DATA: begin
                        if (r_adv_left == 8'd1) begin
                            n_phase = basp_pkg::PH_RSSI;
                        end
                    end
                    basp_pkg::PH_RSSI: begin
                        n_phase = (r_reports_left == 8'd1) ? basp_pkg::PH_DONE
                                                           : basp_pkg::PH_EVT_TYPE;
                    end
                    default: ;
                endcase
            end
            if (i_last_byte) begin
                n_phase = basp_pkg::PH_IDLE;
            end
        end
    end

    // field state and requests to the queue
    always_comb begin
        n_reports_left = r_reports_left;
        n_field_cnt    = r_field_cnt;
        n_addr_shift   = r_addr_shift;
        n_match_valid  = r_match_valid;
        n_match_idx    = r_match_idx;
        n_adv_left     = r_adv_left;
        n_ad_len       = r_ad_len;
        n_ad_pos       = r_ad_pos;
        n_ad_mfr       = r_ad_mfr;
        n_ad_ok        = r_ad_ok;
        n_temp_lo      = r_temp_lo;
        n_temp_stage   = r_temp_stage;
        n_pending      = r_pending;
        o_req          = '0;
        o_req.reading  = {r_temp_stage, i_data_byte};
        o_req.dev      = r_match_idx;
        o_req.rssi     = i_data_byte;
        if (i_accept) begin
            if (i_first_byte) begin
                n_pending   = '0;
                o_req.abort = 1'b1;
                if (i_subevent == basp_pkg::SUB_ADV_REPORT) begin
                    n_reports_left = i_data_byte;
                end
            end else begin
                case (r_phase)
                    basp_pkg::PH_ADDR_TYPE: begin
                        n_field_cnt  = '0;
                        n_addr_shift = '0;
                    end
                    basp_pkg::PH_ADDR: begin
                        n_addr_shift = addr_next;
                        n_field_cnt  = r_field_cnt + 3'd1;
                        if (r_field_cnt == basp_pkg::ADDR_LAST_BYTE) begin
                            n_match_valid = hit;
                            n_match_idx   = hit_idx;
                        end
                    end
                    basp_pkg::PH_DATA_LEN: begin
                        n_adv_left  = i_data_byte;
                        n_ad_pos    = basp_pkg::POS_LEN;
                        n_ad_len    = '0;
                        n_ad_mfr    = 1'b0;
                        n_ad_ok     = r_match_valid;
                        n_pending   = '0;
                        o_req.abort = 1'b1;
                    end
                    basp_pkg::PH_DATA: begin
                        n_adv_left = r_adv_left - 8'd1;
                        if (r_ad_ok) begin
                            if (r_ad_pos == basp_pkg::POS_LEN) begin
                                // structure must fit in what is left of the data
                                if (r_adv_left < 8'd2 ||
                                    ({1'b0, i_data_byte} + 9'd1) > {1'b0, r_adv_left}) begin
                                    n_ad_ok = 1'b0;
                                end else begin
                                    n_ad_len = i_data_byte;
                                    n_ad_pos = (i_data_byte == 8'd0) ? basp_pkg::POS_LEN
                                                                     : basp_pkg::POS_TYPE;
                                end
                            end else begin
                                case (r_ad_pos)
                                    basp_pkg::POS_TYPE: begin
                                        n_ad_mfr = (i_data_byte == basp_pkg::AD_TYPE_MFR);
                                    end
                                    basp_pkg::POS_SIG: begin
                                        if (i_data_byte != basp_pkg::MFR_SIGNATURE) begin
                                            n_ad_mfr = 1'b0;
                                        end
                                    end
                                    basp_pkg::POS_TLO: n_temp_lo = i_data_byte;
                                    basp_pkg::POS_THI: n_temp_stage = {i_data_byte, r_temp_lo};
                                    basp_pkg::POS_HUM: begin
                                        if (r_ad_mfr && r_ad_len >= basp_pkg::MFR_MIN_LEN &&
                                            r_pending < CW'(PENDING_DEPTH)) begin
                                            o_req.wr  = 1'b1;
                                            n_pending = r_pending + CW'(1);
                                        end
                                    end
                                    default: ;
                                endcase
                                n_ad_pos = (r_ad_pos == r_ad_len) ? basp_pkg::POS_LEN
                                                                  : r_ad_pos + 8'd1;
                            end
                        end
                    end
                    basp_pkg::PH_RSSI: begin
                        o_req.commit   = 1'b1;
                        n_pending      = '0;
                        n_reports_left = r_reports_left - 8'd1;
                    end
                    default: ;
                endcase
            end
            if (i_last_byte) begin
                n_pending   = '0;
                o_req.abort = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= basp_pkg::PH_IDLE;
            r_reports_left <= '0;
            r_field_cnt    <= '0;
            r_match_valid  <= 1'b0;
            r_match_idx    <= '0;
            r_adv_left     <= '0;
            r_ad_len       <= '0;
            r_ad_pos       <= '0;
            r_ad_mfr       <= 1'b0;
            r_ad_ok        <= 1'b0;
            r_pending      <= '0;
        end else begin
            r_phase        <= n_phase;
            r_reports_left <= n_reports_left;
            r_field_cnt    <= n_field_cnt;
            r_match_valid  <= n_match_valid;
            r_match_idx    <= n_match_idx;
            r_adv_left     <= n_adv_left;
            r_ad_len       <= n_ad_len;
            r_ad_pos       <= n_ad_pos;
            r_ad_mfr       <= n_ad_mfr;
            r_ad_ok        <= n_ad_ok;
            r_pending      <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr_shift <= n_addr_shift;
        r_temp_lo    <= n_temp_lo;
        r_temp_stage <= n_temp_stage;
    end

endmodule

@@ rtl/basp_queue.sv @@
// basp_queue: reading store with tentative writes, report record queue and output register
// readings become visible only when their report commits; depends on basp_pkg
module basp_queue #(
    parameter int PENDING_DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  basp_pkg::t_fe_req   i_req,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_device_index,
    output logic [15:0]         o_temperature,
    output logic [7:0]          o_humidity,
    output logic [7:0]          o_rssi,
    output logic                o_run_last
);

    localparam int AW    = $clog2(2 * PENDING_DEPTH);
    localparam int DEPTH = 1 << AW;
    localparam int PW    = AW + 1;
    localparam int CW    = $clog2(PENDING_DEPTH + 1);
    localparam int RPW   = basp_pkg::RPT_AW + 1;

    basp_pkg::t_reading r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_commit_ptr, r_rd_ptr;

    logic [2:0]    r_rpt_dev  [basp_pkg::RPT_DEPTH];
    logic [7:0]    r_rpt_rssi [basp_pkg::RPT_DEPTH];
    logic [CW-1:0] r_rpt_cnt  [basp_pkg::RPT_DEPTH];
    logic [RPW-1:0] r_rpt_wr, r_rpt_rd;
    logic [CW-1:0] r_taken;

    logic          r_out_valid;
    basp_pkg::t_reading r_out_reading;
    logic [2:0]    r_out_dev;
    logic [7:0]    r_out_rssi;
    logic          r_out_last;

    logic [PW-1:0] occupancy, tentative;
    logic          store_full, rpt_full, avail, load, head_last;
    logic [basp_pkg::RPT_AW-1:0] head;

    assign occupancy  = r_wr_ptr - r_rd_ptr;
    assign tentative  = r_wr_ptr - r_commit_ptr;
    assign store_full = (occupancy == PW'(DEPTH));
    assign rpt_full   = ((r_rpt_wr - r_rpt_rd) == RPW'(basp_pkg::RPT_DEPTH));
    assign o_full     = store_full || rpt_full;
    assign avail      = (r_commit_ptr != r_rd_ptr);
    assign load       = avail && (!r_out_valid || !i_out_stall);
    assign head       = r_rpt_rd[basp_pkg::RPT_AW-1:0];
    assign head_last  = ((r_taken + CW'(1)) == r_rpt_cnt[head]);

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_req.reading;
        end
    end

    // report records: only reports with at least one reading are queued
    always_ff @(posedge i_clk) begin
        if (i_req.commit && tentative != '0) begin
            r_rpt_dev[r_rpt_wr[basp_pkg::RPT_AW-1:0]]  <= i_req.dev;
            r_rpt_rssi[r_rpt_wr[basp_pkg::RPT_AW-1:0]] <= i_req.rssi;
            r_rpt_cnt[r_rpt_wr[basp_pkg::RPT_AW-1:0]]  <= tentative[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_commit_ptr <= '0;
            r_rd_ptr     <= '0;
            r_rpt_wr     <= '0;
            r_rpt_rd     <= '0;
            r_taken      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // commit wins over an abort in the same cycle (rssi byte that ends the event)
            if (i_req.commit) begin
                r_commit_ptr <= r_wr_ptr;
                if (tentative != '0) begin
                    r_rpt_wr <= r_rpt_wr + RPW'(1);
                end
            end else if (i_req.abort) begin
                r_wr_ptr <= r_commit_ptr;
            end else if (i_req.wr) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end

            if (load) begin
                r_rd_ptr    <= r_rd_ptr + PW'(1);
                r_out_valid <= 1'b1;
                if (head_last) begin
                    r_taken  <= '0;
                    r_rpt_rd <= r_rpt_rd + RPW'(1);
                end else begin
                    r_taken <= r_taken + CW'(1);
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_reading <= r_mem[r_rd_ptr[AW-1:0]];
            r_out_dev     <= r_rpt_dev[head];
            r_out_rssi    <= r_rpt_rssi[head];
            r_out_last    <= head_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_device_index = r_out_dev;
    assign o_temperature  = r_out_reading.temp;
    assign o_humidity     = r_out_reading.hum;
    assign o_rssi         = r_out_rssi;
    assign o_run_last     = r_out_last;

endmodule

@@ rtl/basp_checker.sv @@
// basp_checker: port-level assertions for ble_adv_sensor_report_parser
// bound to the top level below; sees its ports only
module basp_checker #(
    parameter int DEVICE_COUNT = 6
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [2:0]        o_device_index,
    input logic [15:0]       o_temperature_tenths,
    input logic [7:0]        o_humidity,
    input logic [7:0]        o_rssi,
    input logic              o_run_last
);

    // a result waiting under stall keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_device_index) &&
        $stable(o_temperature_tenths) && $stable(o_humidity) && $stable(o_rssi) &&
        $stable(o_run_last))
        else $error("output changed while stalled");

    // reset empties the queue: nothing offered, nothing held back
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("queue not empty after reset");

    // device index always names a configured address slot
    a_dev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> int'(o_device_index) < DEVICE_COUNT)
        else $error("device index out of range");

    // the next result after a non-final one belongs to the same device
    a_run_dev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_run_last ##1 o_out_valid
        |-> o_device_index == $past(o_device_index))
        else $error("device changed inside a report");

endmodule

bind ble_adv_sensor_report_parser basp_checker #(
    .DEVICE_COUNT (DEVICE_COUNT)
) u_basp_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_in_stall           (o_in_stall),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_device_index       (o_device_index),
    .o_temperature_tenths (o_temperature_tenths),
    .o_humidity           (o_humidity),
    .o_rssi               (o_rssi),
    .o_run_last           (o_run_last)
);

@@ tb/ble_adv_sensor_report_parser_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for the advertising report sensor parser: streams hci event bytes,
// predicts the sensor readings of matched reports and checks them in order
// depends on basp_pkg and ble_adv_sensor_report_parser
module ble_adv_sensor_report_parser_tb;

    localparam int PENDING_DEPTH = 8;
    localparam int DEVICE_COUNT  = 6;
    localparam int ADDR_BYTES    = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        logic [7:0] code;
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_hci_byte;

    typedef struct {
        logic [2:0]         dev;
        logic signed [15:0] temp;
        logic [7:0]         hum;
        logic signed [7:0]  rssi;
        logic               last;
    } t_sensor_reading;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [7:0]                        i_subevent = '0;
    logic [7:0]                        i_data_byte = '0;
    logic                              i_first_byte = 1'b0;
    logic                              i_last_byte = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic [2:0]                        o_device_index;
    logic signed [15:0]                o_temperature_tenths;
    logic [7:0]                        o_humidity;
    logic signed [7:0]                 o_rssi;
    logic                              o_run_last;
    logic                              i_cfg_we = 1'b0;
    logic [basp_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [basp_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    ble_adv_sensor_report_parser #(
        .PENDING_DEPTH(PENDING_DEPTH),
        .DEVICE_COUNT (DEVICE_COUNT)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_subevent          (i_subevent),
        .i_data_byte         (i_data_byte),
        .i_first_byte        (i_first_byte),
        .i_last_byte         (i_last_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_device_index      (o_device_index),
        .o_temperature_tenths(o_temperature_tenths),
        .o_humidity          (o_humidity),
        .o_rssi              (o_rssi),
        .o_run_last          (o_run_last),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // config copy
    logic [basp_pkg::ADDR_W-1:0] known_addr[DEVICE_COUNT] = '{default: '0};
    logic [basp_pkg::MASK_W-1:0] enable_bits = '0;

    // parser state copy
    basp_pkg::t_phase parse_ph = basp_pkg::PH_IDLE;
    logic [7:0]   rpt_left = '0;
    logic [7:0]   addr_cnt = '0;
    logic [47:0]  addr_acc = '0;
    logic         hit = 1'b0;
    logic [2:0]   hit_idx = '0;
    logic [7:0]   data_left = '0;
    logic [7:0]   ad_len = '0;
    logic [7:0]   ad_type = '0;
    logic [7:0]   ad_pos = '0;
    logic         ad_walk = 1'b0;
    logic [7:0]   temp_lo_byte = '0;
    logic [15:0]  temp_word = '0;
    basp_pkg::t_reading held_rd[PENDING_DEPTH];
    int           held_n = 0;

    t_hci_byte       pend_bytes[$];
    t_sensor_reading readings_due[$];
    t_hci_byte       cur_byte;
    t_sensor_reading seen_want;

    int fails = 0;
    int bytes_queued = 0;
    int bytes_taken = 0;
    int stim_count = 0;
    int tx_gap_left = 0;
    int rx_gap_left = 0;
    int hold_left = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int hit_pct = 70;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom());
    endfunction

    function automatic logic [basp_pkg::ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return r[basp_pkg::ADDR_W-1:0];
        endcase
    endfunction

    function automatic logic [basp_pkg::ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 99) < hit_pct)
            return known_addr[$urandom_range(0, DEVICE_COUNT - 1)];
        return rand_addr();
    endfunction

    // expected readings of one accepted event byte
    function automatic void track_event_byte(t_hci_byte eb);
        t_sensor_reading rd;
        if (eb.first) begin
            held_n = 0;
            if (eb.code != basp_pkg::SUB_ADV_REPORT) begin
                parse_ph = basp_pkg::PH_IDLE;
            end else begin
                rpt_left = eb.data;
                parse_ph = (eb.data == 0) ? basp_pkg::PH_DONE : basp_pkg::PH_EVT_TYPE;
            end
        end else begin
            case (parse_ph)
                basp_pkg::PH_EVT_TYPE: parse_ph = basp_pkg::PH_ADDR_TYPE;
                basp_pkg::PH_ADDR_TYPE: begin
                    addr_cnt = '0;
                    addr_acc = '0;
                    parse_ph = basp_pkg::PH_ADDR;
                end
                basp_pkg::PH_ADDR: begin
                    addr_acc = {addr_acc[39:0], eb.data};
                    addr_cnt++;
                    if (addr_cnt == ADDR_BYTES) begin
                        hit = 1'b0;
                        hit_idx = '0;
                        // scan downward so the lowest enabled match wins
                        for (int i = DEVICE_COUNT - 1; i >= 0; i--) begin
                            if (enable_bits[i] && known_addr[i] == addr_acc) begin
                                hit = 1'b1;
                                hit_idx = 3'(i);
                            end
                        end
                        parse_ph = basp_pkg::PH_DATA_LEN;
                    end
                end
                basp_pkg::PH_DATA_LEN: begin
                    data_left = eb.data;
                    ad_pos = basp_pkg::POS_LEN;
                    ad_len = '0;
                    ad_type = '0;
                    ad_walk = hit;
                    held_n = 0;
                    parse_ph = (eb.data == 0) ? basp_pkg::PH_RSSI : basp_pkg::PH_DATA;
                end
                basp_pkg::PH_DATA: begin
                    if (ad_walk) begin
                        if (ad_pos == basp_pkg::POS_LEN) begin
                            // structure that would run past the data stops the walk
                            if (data_left < 2 ||
                                {1'b0, eb.data} + 9'd1 > {1'b0, data_left}) begin
                                ad_walk = 1'b0;
                            end else begin
                                ad_len = eb.data;
                                ad_pos = (eb.data == 0) ? basp_pkg::POS_LEN
                                                        : basp_pkg::POS_TYPE;
                            end
                        end else begin
                            case (ad_pos)
                                basp_pkg::POS_TYPE: ad_type = eb.data;
                                basp_pkg::POS_SIG:
                                    if (eb.data != basp_pkg::MFR_SIGNATURE) ad_type = '0;
                                basp_pkg::POS_TLO: temp_lo_byte = eb.data;
                                basp_pkg::POS_THI: temp_word = {eb.data, temp_lo_byte};
                                basp_pkg::POS_HUM: begin
                                    if (ad_type == basp_pkg::AD_TYPE_MFR &&
                                        ad_len >= basp_pkg::MFR_MIN_LEN &&
                                        held_n < PENDING_DEPTH) begin
                                        held_rd[held_n] = {temp_word, eb.data};
                                        held_n++;
                                    end
                                end
                                default: ;
                            endcase
                            ad_pos = (ad_pos == ad_len) ? basp_pkg::POS_LEN : ad_pos + 8'd1;
                        end
                    end
                    data_left--;
                    if (data_left == 0) parse_ph = basp_pkg::PH_RSSI;
                end
                basp_pkg::PH_RSSI: begin
                    for (int k = 0; k < held_n; k++) begin
                        rd.dev  = hit_idx;
                        rd.temp = held_rd[k].temp;
                        rd.hum  = held_rd[k].hum;
                        rd.rssi = eb.data;
                        rd.last = (k == held_n - 1);
                        readings_due.push_back(rd);
                    end
                    held_n = 0;
                    rpt_left--;
                    parse_ph = (rpt_left == 0) ? basp_pkg::PH_DONE : basp_pkg::PH_EVT_TYPE;
                end
                default: ;
            endcase
        end
        if (eb.last) begin
            parse_ph = basp_pkg::PH_IDLE;
            held_n = 0;
        end
    endfunction

    task automatic write_reg(input logic [basp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [basp_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == basp_pkg::CFG_MASK_IDX) enable_bits = val[basp_pkg::MASK_W-1:0];
        else known_addr[idx] = val[basp_pkg::ADDR_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic shuffle_config();
        int r;
        for (int i = 0; i < DEVICE_COUNT; i++)
            if ($urandom_range(0, 1) == 1) write_reg(basp_pkg::CFG_IDX_W'(i), rand_addr());
        // occasional duplicate address
        if ($urandom_range(0, 3) == 0)
            write_reg(basp_pkg::CFG_IDX_W'($urandom_range(1, DEVICE_COUNT - 1)),
                      known_addr[$urandom_range(0, DEVICE_COUNT - 1)]);
        r = $urandom_range(0, 99);
        if (r < 35) write_reg(basp_pkg::CFG_MASK_IDX, '1);
        else if (r < 45) write_reg(basp_pkg::CFG_MASK_IDX, '0);
        else write_reg(basp_pkg::CFG_MASK_IDX,
                       basp_pkg::CFG_DATA_W'($urandom_range(0, 63)));
    endtask

    // builds one event; cut_short drops its tail, leave_open omits the closing flag
    task automatic queue_event(input logic [7:0] code, input int n_rep, input int max_ad,
                               input int sensor_pct, input bit cut_short, input bit leave_open);
        logic [7:0]                  evt[$];
        logic [basp_pkg::ADDR_W-1:0] a;
        logic [7:0]                  sig;
        t_hci_byte                   eb;
        int                          len_at, n_ad, k, sl;
        evt.push_back(8'(n_rep));
        for (int r = 0; r < n_rep; r++) begin
            evt.push_back(rnd8());
            evt.push_back(rnd8());
            a = pick_address();
            for (int b = ADDR_BYTES - 1; b >= 0; b--) evt.push_back(a[b*8 +: 8]);
            len_at = evt.size();
            evt.push_back(8'd0);
            n_ad = $urandom_range(0, max_ad);
            for (int s = 0; s < n_ad && evt.size() - len_at < 200; s++) begin
                k = $urandom_range(0, 99);
                if (k < sensor_pct) begin
                    sl = $urandom_range(5, 7);
                    evt.push_back(8'(sl));
                    evt.push_back(basp_pkg::AD_TYPE_MFR);
                    evt.push_back(basp_pkg::MFR_SIGNATURE);
                    repeat (sl - 2) evt.push_back(rnd8());
                end else begin
                    case ($urandom_range(0, 4))
                        0: begin
                            sig = rnd8();
                            if (sig == basp_pkg::MFR_SIGNATURE) sig = ~sig;
                            evt.push_back(basp_pkg::MFR_MIN_LEN);
                            evt.push_back(basp_pkg::AD_TYPE_MFR);
                            evt.push_back(sig);
                            repeat (3) evt.push_back(rnd8());
                        end
                        1: begin
                            sl = $urandom_range(1, 6);
                            evt.push_back(8'(sl));
                            repeat (sl) evt.push_back(rnd8());
                        end
                        2: begin
                            sl = $urandom_range(3, 4);
                            evt.push_back(8'(sl));
                            evt.push_back(basp_pkg::AD_TYPE_MFR);
                            evt.push_back(basp_pkg::MFR_SIGNATURE);
                            repeat (sl - 2) evt.push_back(rnd8());
                        end
                        3: evt.push_back(8'd0);
                        default: begin
                            // length running past the end of the data
                            evt.push_back(8'($urandom_range(10, 255)));
                            repeat ($urandom_range(0, 3)) evt.push_back(rnd8());
                            break;
                        end
                    endcase
                end
            end
            evt[len_at] = 8'(evt.size() - len_at - 1);
            evt.push_back(rnd8());
        end
        // trailing bytes after the last report are ignored
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) evt.push_back(rnd8());
        if (cut_short) begin
            evt[0] = 8'($urandom_range(n_rep, 255));
            if (evt.size() > 1) repeat ($urandom_range(1, evt.size() - 1)) void'(evt.pop_back());
        end
        foreach (evt[i]) begin
            eb.code  = (i == 0 || $urandom_range(0, 9) != 0) ? code : rnd8();
            eb.data  = evt[i];
            eb.first = (i == 0);
            eb.last  = (i == evt.size() - 1) && !leave_open;
            pend_bytes.push_back(eb);
            bytes_queued++;
        end
        if (code == basp_pkg::SUB_ADV_REPORT) stim_count += evt.size();
    endtask

    task automatic queue_stray(input int n);
        t_hci_byte eb;
        repeat (n) begin
            eb.code  = rnd8();
            eb.data  = rnd8();
            eb.first = 1'b0;
            eb.last  = ($urandom_range(0, 3) == 0);
            pend_bytes.push_back(eb);
            bytes_queued++;
        end
    endtask

    task automatic queue_sensor_report(input logic [basp_pkg::ADDR_W-1:0] a,
                                       input logic [15:0] t0, input logic [7:0] h0,
                                       input logic [15:0] t1, input logic [7:0] h1,
                                       input logic [7:0] rssi);
        logic [7:0] evt[$];
        t_hci_byte  eb;
        evt = '{8'd1, 8'd0, 8'd0};
        for (int b = ADDR_BYTES - 1; b >= 0; b--) evt.push_back(a[b*8 +: 8]);
        evt.push_back(8'd12);
        evt.push_back(basp_pkg::MFR_MIN_LEN);
        evt.push_back(basp_pkg::AD_TYPE_MFR);
        evt.push_back(basp_pkg::MFR_SIGNATURE);
        evt.push_back(t0[7:0]);
        evt.push_back(t0[15:8]);
        evt.push_back(h0);
        evt.push_back(basp_pkg::MFR_MIN_LEN);
        evt.push_back(basp_pkg::AD_TYPE_MFR);
        evt.push_back(basp_pkg::MFR_SIGNATURE);
        evt.push_back(t1[7:0]);
        evt.push_back(t1[15:8]);
        evt.push_back(h1);
        evt.push_back(rssi);
        foreach (evt[i]) begin
            eb.code  = basp_pkg::SUB_ADV_REPORT;
            eb.data  = evt[i];
            eb.first = (i == 0);
            eb.last  = (i == evt.size() - 1);
            pend_bytes.push_back(eb);
            bytes_queued++;
        end
        stim_count += evt.size();
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (bytes_taken != bytes_queued) @(posedge i_clk);
        while (readings_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (readings_due.size() != 0) begin
            $error("%0d expected readings never came out", readings_due.size());
            fails++;
            readings_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                track_event_byte(cur_byte);
                bytes_taken++;
            end
            if (i_in_valid && o_in_stall) begin
                // payload held while stalled
            end else if (tx_gap_left > 0) begin
                tx_gap_left--;
                i_in_valid <= 1'b0;
            end else if (pend_bytes.size() != 0) begin
                cur_byte = pend_bytes.pop_front();
                i_in_valid <= 1'b1;
                i_subevent <= cur_byte.code;
                i_data_byte <= cur_byte.data;
                i_first_byte <= cur_byte.first;
                i_last_byte <= cur_byte.last;
                tx_gap_left = tx_burst ? 0 : idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure, with long holds on demand
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_served != hold_reqs) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (rx_gap_left > 0) begin
            i_out_stall <= 1'b1;
            rx_gap_left--;
        end else begin
            i_out_stall <= 1'b0;
            rx_gap_left = rx_burst ? 0 : idle_len();
        end
    end

    // reading monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (readings_due.size() == 0) begin
                $error("unexpected reading: device_index %0d temperature_tenths %0d",
                       o_device_index, o_temperature_tenths);
                fails++;
            end else begin
                seen_want = readings_due.pop_front();
                if (o_device_index !== seen_want.dev) begin
                    $error("device_index: expected %0d, got %0d", seen_want.dev, o_device_index);
                    fails++;
                end
                if (o_temperature_tenths !== seen_want.temp) begin
                    $error("temperature_tenths: expected %0d, got %0d",
                           seen_want.temp, o_temperature_tenths);
                    fails++;
                end
                if (o_humidity !== seen_want.hum) begin
                    $error("humidity: expected %0d, got %0d", seen_want.hum, o_humidity);
                    fails++;
                end
                if (o_rssi !== seen_want.rssi) begin
                    $error("rssi: expected %0d, got %0d", seen_want.rssi, o_rssi);
                    fails++;
                end
                if (o_run_last !== seen_want.last) begin
                    $error("run_last: expected %0d, got %0d", seen_want.last, o_run_last);
                    fails++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int k, start, phase_no;
        logic [7:0] other;
        phase_no = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(basp_pkg::CFG_IDX_W'(0), '1);
        write_reg(basp_pkg::CFG_IDX_W'(1), '0);
        for (int i = 2; i < DEVICE_COUNT; i++) write_reg(basp_pkg::CFG_IDX_W'(i), rand_addr());
        write_reg(basp_pkg::CFG_MASK_IDX, '1);

        // extremes of temperature, humidity and rssi, empty event, foreign subevent
        queue_sensor_report('1, 16'h7FFF, 8'h00, 16'h8000, 8'hFF, 8'h80);
        queue_event(basp_pkg::SUB_ADV_REPORT, 0, 0, 0, 1'b0, 1'b0);
        queue_event(8'h3E, 0, 0, 0, 1'b0, 1'b0);
        drain();

        // long receiver hold while the sender keeps streaming matched reports
        for (int i = 0; i < DEVICE_COUNT; i++)
            write_reg(basp_pkg::CFG_IDX_W'(i), {$urandom(), 13'(i), 3'(i)});
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        hit_pct = 100;
        hold_reqs++;
        queue_event(basp_pkg::SUB_ADV_REPORT, 8, 6, 100, 1'b0, 1'b0);
        drain();
        hit_pct = 70;

        while (stim_count < 500 && phase_no < 60) begin
            if ($urandom_range(0, 2) == 0) shuffle_config();
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            start = stim_count;
            while (stim_count - start < 80) begin
                k = $urandom_range(0, 99);
                if (k < 68) begin
                    queue_event(basp_pkg::SUB_ADV_REPORT, $urandom_range(1, 3), 4, 55,
                                1'b0, 1'b0);
                end else if (k < 78) begin
                    queue_event(basp_pkg::SUB_ADV_REPORT, $urandom_range(1, 4), 4, 55,
                                1'b1, 1'b0);
                end else if (k < 85) begin
                    queue_event(basp_pkg::SUB_ADV_REPORT, $urandom_range(1, 2), 3, 55,
                                1'b0, 1'b1);
                end else if (k < 90) begin
                    other = rnd8();
                    if (other == basp_pkg::SUB_ADV_REPORT) other = ~other;
                    queue_event(other, $urandom_range(0, 2), 2, 50, 1'b0, 1'b0);
                end else if (k < 94) begin
                    queue_stray($urandom_range(1, 4));
                end else if (k < 97) begin
                    queue_event(basp_pkg::SUB_ADV_REPORT, 0, 0, 0, 1'b0, 1'b0);
                end else begin
                    // more readings than the pending store holds
                    queue_event(basp_pkg::SUB_ADV_REPORT, $urandom_range(1, 2), 12, 90,
                                1'b0, 1'b0);
                end
            end
            // close any open event before the next config change
            queue_event(basp_pkg::SUB_ADV_REPORT, 1, 3, 60, 1'b0, 1'b0);
            drain();
            phase_no++;
        end

        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ ble_adv_sensor_report_parser.f @@
rtl/basp_pkg.sv
rtl/basp_front.sv
rtl/basp_queue.sv
rtl/ble_adv_sensor_report_parser.sv
rtl/basp_checker.sv
tb/ble_adv_sensor_report_parser_tb.sv
